@@ rtl/basic_source_tokenizer_unit_macros.svh @@
// Assertion helpers for the tokenizer. Each use sits at the end of a module
// that has clk_i and rst_ni in scope.
`ifndef BASIC_SOURCE_TOKENIZER_UNIT_MACROS_SVH
`define BASIC_SOURCE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSTU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BSTU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ rtl/bst_pkg.sv @@
package bst_pkg;

  // Token codes as seen on token_kind_o.
  typedef enum logic [5:0] {
    TK_PLUS    = 6'd0,
    TK_MINUS   = 6'd1,
    TK_STAR    = 6'd2,
    TK_SLASH   = 6'd3,
    TK_LPAREN  = 6'd4,
    TK_RPAREN  = 6'd5,
    TK_EQUAL   = 6'd6,
    TK_COMMA   = 6'd7,
    TK_PERCENT = 6'd8,
    TK_AMP     = 6'd9,
    TK_BANG    = 6'd10,
    TK_HASH    = 6'd11,
    TK_DOLLAR  = 6'd12,
    TK_NE      = 6'd13,
    TK_LE      = 6'd14,
    TK_LT      = 6'd15,
    TK_GE      = 6'd16,
    TK_GT      = 6'd17,
    TK_NEWLINE = 6'd18,
    TK_EOF     = 6'd19,
    TK_STRING  = 6'd20,
    TK_SINGLE  = 6'd21,
    TK_INTEGER = 6'd22,
    TK_KW_DIM  = 6'd23,
    TK_KW_LAST = 6'd46,
    TK_IDENT   = 6'd47,
    TK_UNKNOWN = 6'd48
  } tok_kind_e;

  // Character codes the scanner tests for.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LOWER = 8'h20;

  // Keyword table, in token code order. Literals are right-justified.
  localparam int KW_COUNT = 24;
  localparam int KW_MAX_LEN = 8;
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "dim", "as", "print", "if", "then", "else", "elseif", "end", "exit",
    "select", "case", "for", "step", "next", "continue", "to", "while",
    "wend", "do", "loop", "until", "function", "sub", "declare"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd5, 4'd2, 4'd4, 4'd4, 4'd6, 4'd3, 4'd4, 4'd6, 4'd4, 4'd3,
    4'd4, 4'd4, 4'd8, 4'd2, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd8, 4'd3, 4'd7
  };

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // One result item, with its end-of-step mark.
  typedef struct packed {
    tok_kind_e   kind;
    logic [31:0] value;
    logic        sat;
    logic [31:0] line;
    logic        last;
  } tok_t;

  // Result of the single-character operator lookup.
  typedef struct packed {
    logic      hit;
    tok_kind_e kind;
  } op_hit_t;

  // Keyword text laid out like the word buffer: first character in the
  // lowest byte, unused bytes zero.
  function automatic logic [63:0] kw_key(input logic [4:0] idx);
    logic [63:0] lit;
    logic [63:0] rv;
    lit = KW_TEXT[idx];
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      rv[8*j +: 8] = lit[8*(KW_MAX_LEN-1-j) +: 8];
    end
    return rv >> (7'(8 * (KW_MAX_LEN - int'(KW_LEN[idx]))));
  endfunction

  // Single-character operators.
  function automatic op_hit_t op_lookup(input logic [7:0] c);
    op_hit_t r;
    r.hit = 1'b1;
    r.kind = TK_UNKNOWN;
    case (c)
      "+":     r.kind = TK_PLUS;
      "-":     r.kind = TK_MINUS;
      "*":     r.kind = TK_STAR;
      "/":     r.kind = TK_SLASH;
      "(":     r.kind = TK_LPAREN;
      ")":     r.kind = TK_RPAREN;
      "=":     r.kind = TK_EQUAL;
      ",":     r.kind = TK_COMMA;
      "%":     r.kind = TK_PERCENT;
      "&":     r.kind = TK_AMP;
      "!":     r.kind = TK_BANG;
      "#":     r.kind = TK_HASH;
      "$":     r.kind = TK_DOLLAR;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/basic_source_tokenizer_unit.sv @@
// The token a byte completes is written into the output queue when that byte is taken.
// Throughput: one source byte per cycle while in_ready_o is high; a byte that yields
// two tokens is absorbed by a four-entry output queue that holds off requests
// while more than two tokens wait. The scanner and keyword compare are combinational.
// Reset: asynchronous, active low; scanner idle, line counter one, queue empty.
module basic_source_tokenizer_unit #(
  parameter int KEYWORD_CHARS = 8,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [31:0] token_value_o,
  output logic        value_saturated_o,
  output logic [31:0] line_number_o,
  output logic        is_last_o
);

  `include "basic_source_tokenizer_unit_macros.svh"

  localparam int IDX_W = $clog2(KEYWORD_CHARS);
  localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {VALUE_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LT,
    MODE_GT,
    MODE_STR,
    MODE_STRQ,
    MODE_NUM,
    MODE_WORD
  } mode_e;

  // Low 32 bits of a value, zero-extended when the value is narrower.
  function automatic logic [31:0] low32(input logic [VALUE_WIDTH-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[31:0];
  endfunction

  mode_e                                mode_q, mode_d;
  logic                                 qdbl_q, qdbl_d;
  logic [VALUE_WIDTH-1:0]               acc_q, acc_d;
  logic                                 dot_q, dot_d;
  logic                                 sat_q, sat_d;
  logic [KEYWORD_CHARS-1:0][7:0]        wbuf_q, wbuf_d;
  logic [VALUE_WIDTH-1:0]               rl_q, rl_d;
  logic [31:0]                          line_q, line_d;
  logic [31:0]                          sline_q, sline_d;

  logic [bst_pkg::PTR_W-1:0]            wr_ptr_q, wr_ptr_d;
  logic [bst_pkg::PTR_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [bst_pkg::CNT_W-1:0]            cnt_q, cnt_d;
  bst_pkg::tok_t                        fifo_q [bst_pkg::FIFO_DEPTH];

  logic                                 in_fire;
  logic                                 pop;
  logic [7:0]                           c;
  logic                                 eoi;
  logic [7:0]                           quote;
  logic                                 c_digit;
  logic                                 c_alpha;
  logic [7:0]                           c_fold;
  logic [VALUE_WIDTH-1:0]               rl_grow;
  logic                                 grow_sat;
  logic [VALUE_WIDTH+3:0]               acc_next;
  logic                                 acc_ovf;
  bst_pkg::tok_kind_e                   word_kind;
  bst_pkg::op_hit_t                     op;
  logic                                 pend_emit, idle_emit, do_idle;
  bst_pkg::tok_t                        pend_tok, idle_tok, tok0, tok1;
  logic [1:0]                           tok_n;

  assign in_fire = in_valid_i && in_ready_o;
  assign pop     = out_valid_o && out_ready_i;
  assign c       = char_code_i;
  assign eoi     = end_of_input_i;
  assign quote   = qdbl_q ? bst_pkg::CH_DQ : bst_pkg::CH_SQ;
  assign c_digit = (c >= bst_pkg::CH_ZERO) && (c <= bst_pkg::CH_NINE);
  assign c_alpha = ((c | bst_pkg::CH_LOWER) >= "a") && ((c | bst_pkg::CH_LOWER) <= "z");
  assign c_fold  = c_alpha ? (c | bst_pkg::CH_LOWER) : c;
  assign op      = bst_pkg::op_lookup(c);

  // Length counter step, held at its maximum.
  assign rl_grow  = (rl_q == VAL_MAX) ? rl_q : rl_q + 1'b1;
  assign grow_sat = (rl_grow == VAL_MAX);

  // Decimal accumulate: acc * 10 + digit, with overflow past the value range.
  // The low nibble of an ASCII digit is its value.
  assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                  + (VALUE_WIDTH+4)'(c[3:0]);
  assign acc_ovf  = |acc_next[VALUE_WIDTH+3:VALUE_WIDTH];

  // Parallel keyword compare against the first eight buffered characters.
  always_comb begin
    word_kind = bst_pkg::TK_IDENT;
    for (int k = 0; k < bst_pkg::KW_COUNT; k++) begin
      if ((rl_q == VALUE_WIDTH'(bst_pkg::KW_LEN[k])) &&
          (wbuf_q[bst_pkg::KW_MAX_LEN-1:0] == bst_pkg::kw_key(5'(k)))) begin
        word_kind = bst_pkg::tok_kind_e'(bst_pkg::TK_KW_DIM + 6'(k));
      end
    end
  end

  // Scanner: the pending token that this byte closes, then the byte's own token.
  always_comb begin
    mode_d    = mode_q;
    qdbl_d    = qdbl_q;
    acc_d     = acc_q;
    dot_d     = dot_q;
    sat_d     = sat_q;
    wbuf_d    = wbuf_q;
    rl_d      = rl_q;
    line_d    = line_q;
    sline_d   = sline_q;
    pend_emit = 1'b0;
    idle_emit = 1'b0;
    do_idle   = 1'b0;
    pend_tok  = '0;
    idle_tok  = '0;
    pend_tok.line = sline_q;
    idle_tok.line = line_q;

    if (in_fire) begin
      case (mode_q)
        MODE_LT: begin
          mode_d    = MODE_IDLE;
          pend_emit = 1'b1;
          if (!eoi && c == bst_pkg::CH_GT) begin
            pend_tok.kind = bst_pkg::TK_NE;
          end else if (!eoi && c == bst_pkg::CH_EQ) begin
            pend_tok.kind = bst_pkg::TK_LE;
          end else begin
            pend_tok.kind = bst_pkg::TK_LT;
            do_idle       = 1'b1;
          end
        end
        MODE_GT: begin
          mode_d    = MODE_IDLE;
          pend_emit = 1'b1;
          if (!eoi && c == bst_pkg::CH_EQ) begin
            pend_tok.kind = bst_pkg::TK_GE;
          end else begin
            pend_tok.kind = bst_pkg::TK_GT;
            do_idle       = 1'b1;
          end
        end
        MODE_STR: begin
          if (eoi) begin
            mode_d         = MODE_IDLE;
            pend_emit      = 1'b1;
            pend_tok.kind  = bst_pkg::TK_STRING;
            pend_tok.value = low32(rl_q);
            pend_tok.sat   = sat_q;
            do_idle        = 1'b1;
          end else if (c == quote) begin
            mode_d = MODE_STRQ;
          end else begin
            rl_d  = rl_grow;
            sat_d = sat_q | grow_sat;
          end
        end
        MODE_STRQ: begin
          // A doubled quote stands for one quote character.
          if (!eoi && c == quote) begin
            mode_d = MODE_STR;
            rl_d   = rl_grow;
            sat_d  = sat_q | grow_sat;
          end else begin
            mode_d         = MODE_IDLE;
            pend_emit      = 1'b1;
            pend_tok.kind  = bst_pkg::TK_STRING;
            pend_tok.value = low32(rl_q);
            pend_tok.sat   = sat_q;
            do_idle        = 1'b1;
          end
        end
        MODE_NUM: begin
          if (!eoi && c_digit) begin
            if (!dot_q) begin
              if (acc_ovf) begin
                acc_d = VAL_MAX;
                sat_d = 1'b1;
              end else begin
                acc_d = acc_next[VALUE_WIDTH-1:0];
                if (acc_next[VALUE_WIDTH-1:0] == VAL_MAX) begin
                  sat_d = 1'b1;
                end
              end
            end
          end else if (!eoi && c == bst_pkg::CH_DOT && !dot_q) begin
            dot_d = 1'b1;
          end else begin
            mode_d    = MODE_IDLE;
            pend_emit = 1'b1;
            do_idle   = 1'b1;
            if (dot_q) begin
              pend_tok.kind = bst_pkg::TK_SINGLE;
            end else begin
              pend_tok.kind  = bst_pkg::TK_INTEGER;
              pend_tok.value = low32(acc_q);
              pend_tok.sat   = sat_q;
            end
          end
        end
        MODE_WORD: begin
          if (!eoi && (c_alpha || c_digit)) begin
            if (rl_q < VALUE_WIDTH'(KEYWORD_CHARS)) begin
              wbuf_d[rl_q[IDX_W-1:0]] = c_fold;
            end
            rl_d  = rl_grow;
            sat_d = sat_q | grow_sat;
          end else begin
            mode_d         = MODE_IDLE;
            pend_emit      = 1'b1;
            pend_tok.kind  = word_kind;
            pend_tok.value = low32(rl_q);
            pend_tok.sat   = sat_q;
            do_idle        = 1'b1;
          end
        end
        default: begin
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      endcase

      // Idle scan of the current byte.
      if (do_idle) begin
        if (eoi) begin
          idle_emit     = 1'b1;
          idle_tok.kind = bst_pkg::TK_EOF;
        end else if (c inside {bst_pkg::CH_SPACE, bst_pkg::CH_TAB, bst_pkg::CH_CR,
                               bst_pkg::CH_VT, bst_pkg::CH_FF}) begin
          idle_emit = 1'b0;
        end else if (c == bst_pkg::CH_NL) begin
          idle_emit     = 1'b1;
          idle_tok.kind = bst_pkg::TK_NEWLINE;
          if (line_q != '1) begin
            line_d = line_q + 32'd1;
          end
        end else if (op.hit) begin
          idle_emit     = 1'b1;
          idle_tok.kind = op.kind;
        end else if (c == bst_pkg::CH_LT) begin
          sline_d = line_q;
          mode_d  = MODE_LT;
        end else if (c == bst_pkg::CH_GT) begin
          sline_d = line_q;
          mode_d  = MODE_GT;
        end else if (c == bst_pkg::CH_SQ || c == bst_pkg::CH_DQ) begin
          sline_d = line_q;
          mode_d  = MODE_STR;
          qdbl_d  = (c == bst_pkg::CH_DQ);
          rl_d    = '0;
          sat_d   = 1'b0;
        end else if (c_digit) begin
          sline_d = line_q;
          mode_d  = MODE_NUM;
          acc_d   = VALUE_WIDTH'(c[3:0]);
          dot_d   = 1'b0;
          sat_d   = 1'b0;
        end else if (c_alpha) begin
          sline_d   = line_q;
          mode_d    = MODE_WORD;
          wbuf_d    = '0;
          wbuf_d[0] = c_fold;
          rl_d      = VALUE_WIDTH'(1);
          sat_d     = 1'b0;
        end else begin
          idle_emit     = 1'b1;
          idle_tok.kind = bst_pkg::TK_UNKNOWN;
        end
      end
    end
  end

  // Order the tokens of this request and mark the last one.
  always_comb begin
    tok0  = pend_tok;
    tok1  = idle_tok;
    tok_n = 2'd0;
    if (pend_emit && idle_emit) begin
      tok_n = 2'd2;
    end else if (pend_emit || idle_emit) begin
      tok_n = 2'd1;
      tok0  = pend_emit ? pend_tok : idle_tok;
    end
    tok0.last = (tok_n == 2'd1);
    tok1.last = 1'b1;
  end

  // Output queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q + bst_pkg::PTR_W'(tok_n);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + bst_pkg::CNT_W'(tok_n) - bst_pkg::CNT_W'(pop);
  end

  assign in_ready_o        = (cnt_q <= bst_pkg::CNT_W'(bst_pkg::FIFO_DEPTH - 2));
  assign out_valid_o       = (cnt_q != '0);
  assign token_kind_o      = fifo_q[rd_ptr_q].kind;
  assign token_value_o     = fifo_q[rd_ptr_q].value;
  assign value_saturated_o = fifo_q[rd_ptr_q].sat;
  assign line_number_o     = fifo_q[rd_ptr_q].line;
  assign is_last_o         = fifo_q[rd_ptr_q].last;

  // Scanner state and queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      qdbl_q   <= 1'b0;
      acc_q    <= '0;
      dot_q    <= 1'b0;
      sat_q    <= 1'b0;
      wbuf_q   <= '0;
      rl_q     <= '0;
      line_q   <= 32'd1;
      sline_q  <= 32'd1;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      qdbl_q   <= qdbl_d;
      acc_q    <= acc_d;
      dot_q    <= dot_d;
      sat_q    <= sat_d;
      wbuf_q   <= wbuf_d;
      rl_q     <= rl_d;
      line_q   <= line_d;
      sline_q  <= sline_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue entries take up to two tokens per request.
  always_ff @(posedge clk_i) begin
    if (tok_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= tok0;
    end
    if (tok_n == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= tok1;
    end
  end

  `BSTU_ASSERT_IMPL(a_queue_bound, 1'b1, cnt_q <= bst_pkg::CNT_W'(bst_pkg::FIFO_DEPTH))
  `BSTU_ASSERT_IMPL(a_eof_emits, in_fire && eoi, tok_n != 2'd0)
  `BSTU_ASSERT_NEXT(a_eof_idles, in_fire && eoi, mode_q == MODE_IDLE)
  `BSTU_ASSERT_NEXT(a_line_step,
    in_fire && mode_q == MODE_IDLE && !eoi && c == bst_pkg::CH_NL && line_q != '1,
    line_q == $past(line_q) + 32'd1)

endmodule
